/* hw/rtl/sha256_pkg.sv */
// SHA-256 shared definitions: working-variable struct, round constants,
// initial hash value and the four sigma functions. No dependencies.
`default_nettype none
package sha256_pkg;

	// Command codes carried on cmd
	localparam logic CMD_ABSORB = 1'b0;
	localparam logic CMD_FINISH = 1'b1;

	localparam logic [7:0] PAD_BYTE   = 8'h80;
	localparam logic [5:0] LAST_ROUND = 6'h3f;
	localparam logic [5:0] LAST_BYTE  = 6'h3f;
	localparam logic [5:0] LEN_ROOM   = 6'd55;

	// Eight 32-bit words a..h; used for both hash state and round variables
	typedef struct packed {
		logic [31:0] a;
		logic [31:0] b;
		logic [31:0] c;
		logic [31:0] d;
		logic [31:0] e;
		logic [31:0] f;
		logic [31:0] g;
		logic [31:0] h;
	} sha256_vars_t;

	localparam sha256_vars_t HASH_INIT = '{
		a: 32'h6a09e667, b: 32'hbb67ae85, c: 32'h3c6ef372, d: 32'ha54ff53a,
		e: 32'h510e527f, f: 32'h9b05688c, g: 32'h1f83d9ab, h: 32'h5be0cd19
	};

	function automatic logic [31:0] round_k(input logic [5:0] idx);
		logic [31:0] k;
		case (idx)
			6'd0:  k = 32'h428a2f98;  6'd1:  k = 32'h71374491;
			6'd2:  k = 32'hb5c0fbcf;  6'd3:  k = 32'he9b5dba5;
			6'd4:  k = 32'h3956c25b;  6'd5:  k = 32'h59f111f1;
			6'd6:  k = 32'h923f82a4;  6'd7:  k = 32'hab1c5ed5;
			6'd8:  k = 32'hd807aa98;  6'd9:  k = 32'h12835b01;
			6'd10: k = 32'h243185be;  6'd11: k = 32'h550c7dc3;
			6'd12: k = 32'h72be5d74;  6'd13: k = 32'h80deb1fe;
			6'd14: k = 32'h9bdc06a7;  6'd15: k = 32'hc19bf174;
			6'd16: k = 32'he49b69c1;  6'd17: k = 32'hefbe4786;
			6'd18: k = 32'h0fc19dc6;  6'd19: k = 32'h240ca1cc;
			6'd20: k = 32'h2de92c6f;  6'd21: k = 32'h4a7484aa;
			6'd22: k = 32'h5cb0a9dc;  6'd23: k = 32'h76f988da;
			6'd24: k = 32'h983e5152;  6'd25: k = 32'ha831c66d;
			6'd26: k = 32'hb00327c8;  6'd27: k = 32'hbf597fc7;
			6'd28: k = 32'hc6e00bf3;  6'd29: k = 32'hd5a79147;
			6'd30: k = 32'h06ca6351;  6'd31: k = 32'h14292967;
			6'd32: k = 32'h27b70a85;  6'd33: k = 32'h2e1b2138;
			6'd34: k = 32'h4d2c6dfc;  6'd35: k = 32'h53380d13;
			6'd36: k = 32'h650a7354;  6'd37: k = 32'h766a0abb;
			6'd38: k = 32'h81c2c92e;  6'd39: k = 32'h92722c85;
			6'd40: k = 32'ha2bfe8a1;  6'd41: k = 32'ha81a664b;
			6'd42: k = 32'hc24b8b70;  6'd43: k = 32'hc76c51a3;
			6'd44: k = 32'hd192e819;  6'd45: k = 32'hd6990624;
			6'd46: k = 32'hf40e3585;  6'd47: k = 32'h106aa070;
			6'd48: k = 32'h19a4c116;  6'd49: k = 32'h1e376c08;
			6'd50: k = 32'h2748774c;  6'd51: k = 32'h34b0bcb5;
			6'd52: k = 32'h391c0cb3;  6'd53: k = 32'h4ed8aa4a;
			6'd54: k = 32'h5b9cca4f;  6'd55: k = 32'h682e6ff3;
			6'd56: k = 32'h748f82ee;  6'd57: k = 32'h78a5636f;
			6'd58: k = 32'h84c87814;  6'd59: k = 32'h8cc70208;
			6'd60: k = 32'h90befffa;  6'd61: k = 32'ha4506ceb;
			6'd62: k = 32'hbef9a3f7;  6'd63: k = 32'hc67178f2;
			default: k = 32'h0;
		endcase
		return k;
	endfunction

	function automatic logic [31:0] big_sigma0(input logic [31:0] x);
		return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
	endfunction

	function automatic logic [31:0] big_sigma1(input logic [31:0] x);
		return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
	endfunction

	function automatic logic [31:0] small_sigma0(input logic [31:0] x);
		return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
	endfunction

	function automatic logic [31:0] small_sigma1(input logic [31:0] x);
		return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'b0, x[31:10]};
	endfunction

endpackage
`default_nettype wire

/* hw/rtl/sha256_round.sv */
// One SHA-256 round plus the next message-schedule word, shared by all rounds.
// Depends on sha256_pkg.
`default_nettype none
module sha256_round (
	input  wire sha256_pkg::sha256_vars_t vars,
	input  wire logic [31:0]              k,
	input  wire logic [31:0]              w0,
	input  wire logic [31:0]              w1,
	input  wire logic [31:0]              w9,
	input  wire logic [31:0]              w14,
	output sha256_pkg::sha256_vars_t      vars_next,
	output logic [31:0]                   w_new
);

	logic [31:0] ch;
	logic [31:0] maj;
	logic [31:0] t1;
	logic [31:0] t2;

	assign ch  = (vars.e & vars.f) ^ (~vars.e & vars.g);
	assign maj = (vars.a & vars.b) ^ (vars.a & vars.c) ^ (vars.b & vars.c);
	assign t1  = vars.h + sha256_pkg::big_sigma1(vars.e) + ch + k + w0;
	assign t2  = sha256_pkg::big_sigma0(vars.a) + maj;

	always_comb begin
		vars_next.a = t1 + t2;
		vars_next.b = vars.a;
		vars_next.c = vars.b;
		vars_next.d = vars.c;
		vars_next.e = vars.d + t1;
		vars_next.f = vars.e;
		vars_next.g = vars.f;
		vars_next.h = vars.g;
	end

	// window holds w[r..r+15]; this is w[r+16]
	assign w_new = sha256_pkg::small_sigma1(w14) + w9 + sha256_pkg::small_sigma0(w1) + w0;

endmodule
`default_nettype wire

/* hw/rtl/sha256_message_digest.sv */
// SHA-256 digest over a byte stream: each absorb beat shifts one byte into the block buffer, and
// the 64th byte of a block starts the rounds and hash update, all on the one shared round unit.
// Finish shifts in the pad byte, zero fill and the length bytes (in a second block when the
// length does not fit), with one compression per block (one or two), then 4 digest beats.
// Throughput: one byte per cycle inside a block; the command port stalls during compression.
// Async active-low reset: idle, hash = initial value, byte count zero; block buffer is not reset.
// Depends on sha256_pkg and sha256_round.
`default_nettype none
module sha256_message_digest (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// command channel
	input  wire logic        cmd_valid,
	output logic             cmd_stall,
	input  wire logic        cmd,
	input  wire logic [7:0]  data_byte,
	// digest channel
	output logic             digest_valid,
	input  wire logic        digest_stall,
	output logic [63:0]      digest_word,
	output logic [1:0]       word_index,
	output logic             last_word
);

	// Sequencer states
	typedef enum logic [4:0] {
		ST_IDLE = 5'b00001,  // take command beats
		ST_PAD  = 5'b00010,  // shift in zero fill and length bytes
		ST_COMP = 5'b00100,  // one round per cycle
		ST_ADD  = 5'b01000,  // fold round variables into hash
		ST_OUT  = 5'b10000   // present four digest beats
	} state_t;

	state_t                   state_q;
	sha256_pkg::sha256_vars_t hash_q;
	sha256_pkg::sha256_vars_t vars_q;
	sha256_pkg::sha256_vars_t vars_next;
	logic [63:0]              cnt_q;      // message byte count, wraps at 2^64
	logic [63:0]              bits_q;     // length field, shifted out MSB first
	logic [511:0]             blk_q;      // byte buffer, then schedule window
	logic [5:0]               rnd_q;
	logic [5:0]               pcnt_q;     // bytes in buffer during padding
	logic                     len_q;      // this pad block carries the length
	logic                     done_q;     // next compression is the last one
	logic                     fin_q;      // inside a finish sequence
	logic [1:0]               oi_q;
	logic [31:0]              w_new;
	logic                     cmd_acc;
	logic                     len_byte;
	logic [7:0]               pad_byte;

	assign cmd_stall    = (state_q != ST_IDLE);
	assign cmd_acc      = cmd_valid && !cmd_stall;
	assign digest_valid = (state_q == ST_OUT);
	assign word_index   = oi_q;
	assign last_word    = (oi_q == 2'd3);

	// Last eight bytes of the final block come from the length field
	assign len_byte = len_q && (pcnt_q[5:3] == 3'b111);
	assign pad_byte = len_byte ? bits_q[63:56] : 8'h00;

	always_comb begin
		case (oi_q)
			2'd0:    digest_word = {hash_q.a, hash_q.b};
			2'd1:    digest_word = {hash_q.c, hash_q.d};
			2'd2:    digest_word = {hash_q.e, hash_q.f};
			default: digest_word = {hash_q.g, hash_q.h};
		endcase
	end

	// Window word j sits at blk_q[511-32j -: 32]
	sha256_round u_round (
		.vars      (vars_q),
		.k         (sha256_pkg::round_k(rnd_q)),
		.w0        (blk_q[511:480]),
		.w1        (blk_q[479:448]),
		.w9        (blk_q[223:192]),
		.w14       (blk_q[63:32]),
		.vars_next (vars_next),
		.w_new     (w_new)
	);

	// Control and hash state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			hash_q  <= sha256_pkg::HASH_INIT;
			cnt_q   <= '0;
			rnd_q   <= '0;
			pcnt_q  <= '0;
			len_q   <= 1'b0;
			done_q  <= 1'b0;
			fin_q   <= 1'b0;
			oi_q    <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (cmd_acc) begin
						rnd_q <= '0;
						if (cmd == sha256_pkg::CMD_ABSORB) begin
							cnt_q <= cnt_q + 64'd1;
							fin_q <= 1'b0;
							if (cnt_q[5:0] == sha256_pkg::LAST_BYTE) begin
								state_q <= ST_COMP;
							end
						end else begin
							fin_q  <= 1'b1;
							done_q <= 1'b0;
							pcnt_q <= cnt_q[5:0] + 6'd1;
							// pad byte fills the block: compress before any padding
							len_q  <= (cnt_q[5:0] <= sha256_pkg::LEN_ROOM);
							if (cnt_q[5:0] == sha256_pkg::LAST_BYTE) begin
								state_q <= ST_COMP;
							end else begin
								state_q <= ST_PAD;
							end
						end
					end
				end
				ST_PAD: begin
					pcnt_q <= pcnt_q + 6'd1;
					if (pcnt_q == sha256_pkg::LAST_BYTE) begin
						done_q  <= len_q;
						rnd_q   <= '0;
						state_q <= ST_COMP;
					end
				end
				ST_COMP: begin
					rnd_q <= rnd_q + 6'd1;
					if (rnd_q == sha256_pkg::LAST_ROUND) begin
						state_q <= ST_ADD;
					end
				end
				ST_ADD: begin
					hash_q.a <= hash_q.a + vars_q.a;
					hash_q.b <= hash_q.b + vars_q.b;
					hash_q.c <= hash_q.c + vars_q.c;
					hash_q.d <= hash_q.d + vars_q.d;
					hash_q.e <= hash_q.e + vars_q.e;
					hash_q.f <= hash_q.f + vars_q.f;
					hash_q.g <= hash_q.g + vars_q.g;
					hash_q.h <= hash_q.h + vars_q.h;
					if (!fin_q) begin
						state_q <= ST_IDLE;
					end else if (done_q) begin
						oi_q    <= '0;
						state_q <= ST_OUT;
					end else begin
						// overflow block done, length goes in a fresh one
						len_q   <= 1'b1;
						pcnt_q  <= '0;
						state_q <= ST_PAD;
					end
				end
				ST_OUT: begin
					if (!digest_stall) begin
						oi_q <= oi_q + 2'd1;
						if (oi_q == 2'd3) begin
							hash_q  <= sha256_pkg::HASH_INIT;
							cnt_q   <= '0;
							fin_q   <= 1'b0;
							state_q <= ST_IDLE;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Datapath: byte buffer / schedule window, length field, round variables
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (cmd_acc) begin
					vars_q <= hash_q;
					if (cmd == sha256_pkg::CMD_ABSORB) begin
						blk_q <= {blk_q[503:0], data_byte};
					end else begin
						blk_q  <= {blk_q[503:0], sha256_pkg::PAD_BYTE};
						bits_q <= {cnt_q[60:0], 3'b000};
					end
				end
			end
			ST_PAD: begin
				blk_q  <= {blk_q[503:0], pad_byte};
				vars_q <= hash_q;
				if (len_byte) begin
					bits_q <= {bits_q[55:0], 8'h00};
				end
			end
			ST_COMP: begin
				vars_q <= vars_next;
				blk_q  <= {blk_q[479:0], w_new};
			end
			default: begin
			end
		endcase
	end

	// Digest beats never overlap with command acceptance
	a_out_blocks_in: assert property (@(posedge clk) disable iff (!arst_n)
		digest_valid |-> cmd_stall)
		else $error("digest beat presented while command channel open");

	// Beats step through the four parts in order
	a_index_steps: assert property (@(posedge clk) disable iff (!arst_n)
		(digest_valid && !digest_stall && !last_word) |=>
			(digest_valid && (word_index == $past(word_index) + 2'd1)))
		else $error("digest part order broken");

	// Exactly four beats per finish
	a_last_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(digest_valid && !digest_stall && last_word) |=> !digest_valid)
		else $error("digest beat after last part");

endmodule
`default_nettype wire

/* dv/sha256_message_digest_tb.sv */
// Self-checking testbench for sha256_message_digest: byte streams in, 4-beat digests out.
// Holds its own SHA-256 predictor; needs only sha256_pkg for the command codes.
`default_nettype none
module sha256_message_digest_tb;

	// Idle behavior for a stretch of stimulus; stamped on each beat as it is queued
	typedef enum logic [1:0] {
		GAP_NONE,
		GAP_TX,
		GAP_RX,
		GAP_BOTH
	} gap_mode_t;

	// One command beat plus the sequencing marks the driver acts on
	typedef struct packed {
		logic       op;
		logic [7:0] data;
		gap_mode_t  mode;
		logic       drain_first;  // wait until every digest so far has arrived
		logic       hold_rx;      // kick off a long receiver hold-off
	} cmd_beat_t;

	typedef struct packed {
		logic [63:0] word;
		logic [1:0]  idx;
		logic        last;
	} digest_beat_t;

	localparam int ITEM_TARGET    = 450;
	localparam int ITEMS_PER_MODE = 60;
	localparam int HOLD_CYCLES    = 400;
	// covers two compressions, the pad and length bytes and four digest beats, with margin
	localparam int SETTLE_CYCLES  = 300;
	localparam int QUIET_LIMIT    = 4000;

	localparam logic [255:0] HASH_IV = {
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};

	localparam logic [64*32-1:0] ROUND_CONST = {
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

	logic        clk          = 1'b0;
	logic        arst_n       = 1'b0;
	logic        cmd_valid    = 1'b0;
	logic        cmd          = sha256_pkg::CMD_ABSORB;
	logic [7:0]  data_byte    = 8'h00;
	logic        digest_stall = 1'b0;
	logic        cmd_stall;
	logic        digest_valid;
	logic [63:0] digest_word;
	logic [1:0]  word_index;
	logic        last_word;

	sha256_message_digest u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd_valid    (cmd_valid),
		.cmd_stall    (cmd_stall),
		.cmd          (cmd),
		.data_byte    (data_byte),
		.digest_valid (digest_valid),
		.digest_stall (digest_stall),
		.digest_word  (digest_word),
		.word_index   (word_index),
		.last_word    (last_word)
	);

	always #5 clk = ~clk;

	// ---------------------------------------------------------------------
	// Digest predictor: running hash, partial block and message byte count
	// ---------------------------------------------------------------------
	logic [31:0]  hash_st [8];
	logic [7:0]   blk_buf [64];
	logic [63:0]  msg_bytes;

	cmd_beat_t    stim_q [$];    // beats waiting to be offered
	digest_beat_t digest_q [$];  // predicted digest beats, oldest first
	cmd_beat_t    on_wire;       // beat currently driven on the command port

	int           mismatch_count = 0;
	int           quiet_cycles   = 0;
	gap_mode_t    rx_mode        = GAP_NONE;
	logic         hold_kick      = 1'b0;
	int           hold_left      = 0;

	function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
		return (x >> n) | (x << (32 - n));
	endfunction

	function automatic int tx_gap_pct(input gap_mode_t m);
		case (m)
			GAP_TX:   return 47;
			GAP_BOTH: return 20;
			default:  return 0;
		endcase
	endfunction

	function automatic int rx_stall_pct(input gap_mode_t m);
		case (m)
			GAP_RX:   return 47;
			GAP_BOTH: return 20;
			default:  return 0;
		endcase
	endfunction

	task automatic reset_hash();
		for (int j = 0; j < 8; j++)
			hash_st[j] = HASH_IV[(7 - j) * 32 +: 32];
		msg_bytes = 64'd0;
	endtask

	// One 64-round compression of blk_buf into hash_st
	task automatic compress_block();
		logic [31:0] w [16];
		logic [31:0] v [8];
		logic [31:0] wr, s0, s1, t1, t2;
		for (int j = 0; j < 16; j++)
			w[j] = {blk_buf[4*j], blk_buf[4*j+1], blk_buf[4*j+2], blk_buf[4*j+3]};
		for (int j = 0; j < 8; j++)
			v[j] = hash_st[j];
		for (int r = 0; r < 64; r++) begin
			if (r < 16) begin
				wr = w[r];
			end else begin
				s1 = rotr(w[(r-2) & 15], 17) ^ rotr(w[(r-2) & 15], 19) ^ (w[(r-2) & 15] >> 10);
				s0 = rotr(w[(r-15) & 15], 7) ^ rotr(w[(r-15) & 15], 18) ^ (w[(r-15) & 15] >> 3);
				wr = s1 + w[(r-7) & 15] + s0 + w[r & 15];
				w[r & 15] = wr;
			end
			t1 = v[7] + (rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25)) +
			     ((v[4] & v[5]) ^ (~v[4] & v[6])) + ROUND_CONST[(63 - r) * 32 +: 32] + wr;
			t2 = (rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22)) +
			     ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
			v[7] = v[6];
			v[6] = v[5];
			v[5] = v[4];
			v[4] = v[3] + t1;
			v[3] = v[2];
			v[2] = v[1];
			v[1] = v[0];
			v[0] = t1 + t2;
		end
		for (int j = 0; j < 8; j++)
			hash_st[j] = hash_st[j] + v[j];
	endtask

	task automatic absorb_byte(input logic [7:0] b);
		blk_buf[msg_bytes[5:0]] = b;
		msg_bytes = msg_bytes + 64'd1;
		if (msg_bytes[5:0] == 6'd0)
			compress_block();
	endtask

	// Pad, append the bit length, compress once or twice, queue four digest beats
	task automatic finish_message();
		logic [63:0]  nbits;
		int           pos;
		digest_beat_t d;
		nbits = msg_bytes << 3;
		pos = int'(msg_bytes[5:0]);
		blk_buf[pos] = 8'h80;
		pos++;
		// no room left for the length field: pad this block out, start a fresh one
		if (pos > 56) begin
			for (int j = pos; j < 64; j++)
				blk_buf[j] = 8'h00;
			compress_block();
			pos = 0;
		end
		for (int j = pos; j < 56; j++)
			blk_buf[j] = 8'h00;
		for (int k = 0; k < 8; k++)
			blk_buf[56 + k] = nbits[63 - 8*k -: 8];
		compress_block();
		for (int k = 0; k < 4; k++) begin
			d.word = {hash_st[2*k], hash_st[2*k+1]};
			d.idx  = 2'(k);
			d.last = (k == 3);
			digest_q.push_back(d);
		end
		reset_hash();
	endtask

	initial reset_hash();

	// ---------------------------------------------------------------------
	// Driver: offers queued beats, predicts on every accepted beat
	// ---------------------------------------------------------------------
	always @(posedge clk) begin
		cmd_beat_t fresh;
		logic      offer;
		logic      pick;
		offer = cmd_valid;
		pick  = 1'b0;
		fresh = '0;
		if (cmd_valid && !cmd_stall) begin
			if (on_wire.op == sha256_pkg::CMD_FINISH)
				finish_message();
			else
				absorb_byte(on_wire.data);
			offer = 1'b0;
		end
		// a stalled beat stays on the port untouched; otherwise maybe take the next one
		if (arst_n && !offer && stim_q.size() > 0) begin
			if (!(stim_q[0].drain_first && digest_q.size() != 0) &&
			    $urandom_range(99, 0) >= tx_gap_pct(stim_q[0].mode))
				pick = 1'b1;
		end
		if (pick) begin
			fresh = stim_q.pop_front();
			on_wire   <= fresh;
			cmd       <= fresh.op;
			data_byte <= fresh.data;
			rx_mode   <= fresh.mode;
		end
		cmd_valid <= offer || pick;
		hold_kick <= pick && fresh.hold_rx;
	end

	// ---------------------------------------------------------------------
	// Monitor: checks each digest beat and drives the receiver stall
	// ---------------------------------------------------------------------
	always @(posedge clk) begin
		digest_beat_t want;
		if (digest_valid && !digest_stall) begin
			if (digest_q.size() == 0) begin
				if (mismatch_count < 10)
					$display("unexpected digest beat: word %h index %0d last %0b",
					         digest_word, word_index, last_word);
				mismatch_count++;
			end else begin
				want = digest_q.pop_front();
				if (digest_word !== want.word || word_index !== want.idx ||
				    last_word !== want.last) begin
					if (mismatch_count < 10)
						$display("digest mismatch: expected %h/%0d/%0b got %h/%0d/%0b",
						         want.word, want.idx, want.last,
						         digest_word, word_index, last_word);
					mismatch_count++;
				end
			end
		end
		// long hold-off counted here, independent of the sender
		if (hold_kick)
			hold_left = HOLD_CYCLES;
		else if (hold_left > 0)
			hold_left--;
		digest_stall <= (hold_left > 0) || ($urandom_range(99, 0) < rx_stall_pct(rx_mode));
	end

	// Cycles in which neither channel moved a beat
	always @(posedge clk) begin
		if ((cmd_valid && !cmd_stall) || (digest_valid && !digest_stall))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
	end

	initial begin
		while (quiet_cycles < QUIET_LIMIT)
			@(posedge clk);
		$display("CHECK FAILED");
		$finish;
	end

	// ---------------------------------------------------------------------
	// Stimulus
	// ---------------------------------------------------------------------
	int        item_count   = 0;
	gap_mode_t last_mode    = GAP_NONE;

	// Idle mode rotates every ITEMS_PER_MODE beats; the first beat of a new
	// mode waits for the pipeline to drain so each mode starts clean.
	task automatic push_beat(input logic op, input logic [7:0] b, input logic hold);
		cmd_beat_t t;
		t.op          = op;
		t.data        = b;
		t.mode        = gap_mode_t'((item_count / ITEMS_PER_MODE) % 4);
		t.drain_first = (t.mode != last_mode);
		t.hold_rx     = hold;
		last_mode     = t.mode;
		stim_q.push_back(t);
		item_count++;
	endtask

	task automatic push_message(input int len, input logic hold);
		for (int i = 0; i < len; i++)
			push_beat(sha256_pkg::CMD_ABSORB, 8'($urandom), hold && (i == 0));
		// data on a finish beat is don't-care; drive junk to prove it
		push_beat(sha256_pkg::CMD_FINISH, 8'($urandom), hold && (len == 0));
	endtask

	initial begin
		int msg_no;
		int pick_len;

		// directed: empty message, twice in a row, with a junk byte on finish
		push_beat(sha256_pkg::CMD_FINISH, 8'h00, 1'b0);
		push_beat(sha256_pkg::CMD_FINISH, 8'hff, 1'b0);
		// "abc"
		push_beat(sha256_pkg::CMD_ABSORB, 8'h61, 1'b0);
		push_beat(sha256_pkg::CMD_ABSORB, 8'h62, 1'b0);
		push_beat(sha256_pkg::CMD_ABSORB, 8'h63, 1'b0);
		push_beat(sha256_pkg::CMD_FINISH, 8'h00, 1'b0);
		// single-byte messages at both data extremes, then a two-byte message
		push_beat(sha256_pkg::CMD_ABSORB, 8'h00, 1'b0);
		push_beat(sha256_pkg::CMD_FINISH, 8'h00, 1'b0);
		push_beat(sha256_pkg::CMD_ABSORB, 8'hff, 1'b0);
		push_beat(sha256_pkg::CMD_FINISH, 8'h55, 1'b0);
		push_beat(sha256_pkg::CMD_ABSORB, 8'haa, 1'b0);
		push_beat(sha256_pkg::CMD_ABSORB, 8'h55, 1'b0);
		push_beat(sha256_pkg::CMD_FINISH, 8'hff, 1'b0);

		// random: mostly short messages, many near the one-vs-two compression
		// boundary (55/56 bytes mod 64) and some spanning several blocks
		msg_no = 0;
		while (item_count < ITEM_TARGET) begin
			if (msg_no == 2 || msg_no == 7) begin
				// back-to-back short digests under a long receiver hold-off:
				// the output backs up and the command port has to stall
				push_message(3, 1'b1);
				push_message(0, 1'b0);
				push_message(2, 1'b0);
				push_message(1, 1'b0);
			end
			case ($urandom_range(9, 0))
				0, 1, 2, 3, 4: pick_len = $urandom_range(8, 0);
				5, 6, 7:       pick_len = $urandom_range(66, 52);
				8:             pick_len = $urandom_range(130, 110);
				default:       pick_len = $urandom_range(40, 1);
			endcase
			push_message(pick_len, 1'b0);
			msg_no++;
		end

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// sample between edges so the driver and monitor have settled
		while (stim_q.size() != 0 || cmd_valid || digest_q.size() != 0)
			@(negedge clk);
		// let any stray beats show up before calling it
		repeat (SETTLE_CYCLES) @(posedge clk);

		if (mismatch_count == 0 && digest_q.size() == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
`default_nettype wire
